// ===== rtl/core/pvma_pkg.sv =====
package pvma_pkg;

  // Four plane bytes at one address: plane p lives in byte p.
  typedef logic [3:0][7:0] word_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WRITE_MODE        = 3'd0;
  localparam logic [2:0] CFG_READ_PLANE_SELECT = 3'd1;
  localparam logic [2:0] CFG_SET_RESET_VALUE   = 3'd2;
  localparam logic [2:0] CFG_SET_RESET_ENABLE  = 3'd3;
  localparam logic [2:0] CFG_ALU_FUNCTION      = 3'd4;
  localparam logic [2:0] CFG_ROTATE_COUNT      = 3'd5;
  localparam logic [2:0] CFG_BIT_MASK          = 3'd6;
  localparam logic [2:0] CFG_PLANE_WRITE_MASK  = 3'd7;

  // Write modes.
  localparam logic [1:0] WMODE_0 = 2'd0;
  localparam logic [1:0] WMODE_1 = 2'd1;
  localparam logic [1:0] WMODE_2 = 2'd2;
  localparam logic [1:0] WMODE_3 = 2'd3;

  // ALU functions.
  localparam logic [1:0] ALU_COPY = 2'd0;
  localparam logic [1:0] ALU_AND  = 2'd1;
  localparam logic [1:0] ALU_OR   = 2'd2;
  localparam logic [1:0] ALU_XOR  = 2'd3;

  // Request types.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Each set bit gives an all-ones byte in its plane.
  function automatic word_t expand4(input logic [3:0] bits);
    word_t w;
    for (int p = 0; p < 4; p++) begin
      w[p] = {8{bits[p]}};
    end
    return w;
  endfunction

  // The same byte in all four planes.
  function automatic word_t bcast(input logic [7:0] b);
    return {b, b, b, b};
  endfunction

  // Right rotate of one byte.
  function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] t;
    t = {v, v} >> n;
    return t[7:0];
  endfunction

endpackage

// ===== rtl/core/planar_video_memory_access_unit.sv =====
// Four-plane video memory with graphics-controller write modes.
// Input channel (in_valid/in_stall): one access per item, a read or a write.
// A write stores its result through the byte enables of the plane memory
// at the edge of acceptance and gives no result item. A read loads the
// four plane bytes into the latch and returns the byte of the selected plane.
// Result channel (out_valid/out_stall): one item per read, passed from the
// memory read register into an output register.
// Throughput is one item per cycle while the receiver does not stall and no
// clearing pass runs; the memory has a read port and a byte-enabled write port.
// A write that directly follows a read sees that read's latch value.
// When the receiver stalls, one finished read waits in the latch while the
// output register holds; a further item is then refused until the output
// register is taken.
// Reset clears the configuration, latch and control registers and starts a
// clearing pass writing zero to all PLANE_DEPTH words (65536 by default), one per cycle.
// During the pass in_stall is high; configuration writes are taken as ever.
// PLANE_DEPTH must be a power of two; the address wraps at the depth.
module planar_video_memory_access_unit #(
  parameter int PLANE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(PLANE_DEPTH);

  // Configuration registers.
  logic [1:0] write_mode_r;
  logic [1:0] read_plane_select_r;
  logic [3:0] set_reset_value_r;
  logic [3:0] set_reset_enable_r;
  logic [1:0] alu_function_r;
  logic [2:0] rotate_count_r;
  logic [7:0] bit_mask_r;
  logic [3:0] plane_write_mask_r;

  // Memory, latch and control state.
  pvma_pkg::word_t mem [PLANE_DEPTH];
  pvma_pkg::word_t mem_rd_r;
  pvma_pkg::word_t latch_r;
  pvma_pkg::word_t latch_eff;
  logic            rd_new_r;
  logic            pend_r;
  logic            out_valid_r;
  logic [7:0]      out_read_data_r;
  logic            clearing_r;
  logic [AW-1:0]   clr_cnt_r;

  logic            accept;
  logic            rd_acc;
  logic            wr_acc;
  logic            out_free;
  logic [AW-1:0]   addr;
  logic [7:0]      rot_data;
  pvma_pkg::word_t srx;
  pvma_pkg::word_t sre;
  pvma_pkg::word_t alu_in;
  pvma_pkg::word_t alu_out;
  pvma_pkg::word_t mask;
  pvma_pkg::word_t word;
  pvma_pkg::word_t mem_wdata;
  logic [3:0]      mem_we;
  logic [AW-1:0]   mem_waddr;

  // Handshake.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = clearing_r || (pend_r && !out_free);
  assign accept    = in_valid && !in_stall;
  assign rd_acc    = accept && (in_req_type == pvma_pkg::REQ_READ);
  assign wr_acc    = accept && (in_req_type == pvma_pkg::REQ_WRITE);
  assign addr      = in_address[AW-1:0];
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  // The latch of a read accepted last cycle is still in the memory read register.
  assign latch_eff = rd_new_r ? mem_rd_r : latch_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_mode_r        <= '0;
      read_plane_select_r <= '0;
      set_reset_value_r   <= '0;
      set_reset_enable_r  <= '0;
      alu_function_r      <= '0;
      rotate_count_r      <= '0;
      bit_mask_r          <= '0;
      plane_write_mask_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pvma_pkg::CFG_WRITE_MODE:        write_mode_r        <= cfg_wdata[1:0];
        pvma_pkg::CFG_READ_PLANE_SELECT: read_plane_select_r <= cfg_wdata[1:0];
        pvma_pkg::CFG_SET_RESET_VALUE:   set_reset_value_r   <= cfg_wdata[3:0];
        pvma_pkg::CFG_SET_RESET_ENABLE:  set_reset_enable_r  <= cfg_wdata[3:0];
        pvma_pkg::CFG_ALU_FUNCTION:      alu_function_r      <= cfg_wdata[1:0];
        pvma_pkg::CFG_ROTATE_COUNT:      rotate_count_r      <= cfg_wdata[2:0];
        pvma_pkg::CFG_BIT_MASK:          bit_mask_r          <= cfg_wdata;
        pvma_pkg::CFG_PLANE_WRITE_MASK:  plane_write_mask_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Write data path: pick the ALU operand and the bit mask by write mode.
  always_comb begin
    rot_data = pvma_pkg::rotr8(in_write_data, rotate_count_r);
    srx      = pvma_pkg::expand4(set_reset_value_r);
    sre      = pvma_pkg::expand4(set_reset_enable_r);
    case (write_mode_r)
      pvma_pkg::WMODE_0: begin
        alu_in = (pvma_pkg::bcast(rot_data) & ~sre) | (srx & sre);
        mask   = pvma_pkg::bcast(bit_mask_r);
      end
      pvma_pkg::WMODE_2: begin
        alu_in = pvma_pkg::expand4(in_write_data[3:0]);
        mask   = pvma_pkg::bcast(bit_mask_r);
      end
      pvma_pkg::WMODE_3: begin
        alu_in = srx;
        mask   = pvma_pkg::bcast(rot_data & bit_mask_r);
      end
      default: begin
        alu_in = latch_eff;
        mask   = '1;
      end
    endcase
  end

  // Logic operation with the latch, then merge under the mask; write mode 1 writes the latch as it is.
  always_comb begin
    case (alu_function_r)
      pvma_pkg::ALU_AND: alu_out = alu_in & latch_eff;
      pvma_pkg::ALU_OR:  alu_out = alu_in | latch_eff;
      pvma_pkg::ALU_XOR: alu_out = alu_in ^ latch_eff;
      default:           alu_out = alu_in;
    endcase
    if (write_mode_r == pvma_pkg::WMODE_1) begin
      word = latch_eff;
    end else begin
      word = (alu_out & mask) | (latch_eff & ~mask);
    end
  end

  // Memory write port: the clearing pass, else the accepted write.
  always_comb begin
    if (clearing_r) begin
      mem_we    = '1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_acc ? plane_write_mask_r : '0;
      mem_waddr = addr;
      mem_wdata = word;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      if (mem_we[p]) begin
        mem[mem_waddr][p] <= mem_wdata[p];
      end
    end
  end

  // Memory read port.
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      mem_rd_r <= mem[addr];
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == {AW{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Latch update and read result hand-off to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= '0;
      rd_new_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_new_r <= rd_acc;
      if (rd_new_r) begin
        latch_r <= mem_rd_r;
      end
      if (pend_r && out_free) begin
        out_valid_r     <= 1'b1;
        out_read_data_r <= latch_eff[read_plane_select_r];
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (rd_acc) begin
        pend_r <= 1'b1;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end
    end
  end

  // A result only appears from a finished read waiting in the latch.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result shown without a pending read");

  // An accepted read is pending in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> (pend_r && rd_new_r))
    else $error("accepted read not pending");

  // The clearing pass ends only after the last address.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_cnt_r) == {AW{1'b1}}))
    else $error("clearing pass ended early");

endmodule

// ===== dv/tb_planar_video_memory_access_unit.sv =====
module tb_planar_video_memory_access_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VRAM_DEPTH = 65536;
  localparam int MAX_WAIT = 12;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  // Shadow copy of the planes, the latch and the graphics registers.
  pvma_pkg::word_t vram_shadow [0:VRAM_DEPTH-1];
  pvma_pkg::word_t latch_shadow;
  logic [1:0]  gc_write_mode;
  logic [1:0]  gc_read_plane;
  logic [3:0]  gc_sr_value;
  logic [3:0]  gc_sr_enable;
  logic [1:0]  gc_alu_op;
  logic [2:0]  gc_rotate;
  logic [7:0]  gc_bit_mask;
  logic [3:0]  gc_map_mask;

  // Read bytes still owed by the block, oldest first.
  logic [7:0]  pending_read_bytes [$];
  int          error_count;
  int          reader_hold;
  bit          no_idle;

  planar_video_memory_access_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Each set bit becomes an all-ones byte in its plane.
  function automatic pvma_pkg::word_t plane_spread(input logic [3:0] bits);
    pvma_pkg::word_t w;
    for (int p = 0; p < 4; p++) begin
      w[p] = bits[p] ? 8'hFF : 8'h00;
    end
    return w;
  endfunction

  function automatic pvma_pkg::word_t all_planes(input logic [7:0] b);
    pvma_pkg::word_t w;
    for (int p = 0; p < 4; p++) begin
      w[p] = b;
    end
    return w;
  endfunction

  function automatic logic [7:0] rotate_byte(input logic [7:0] v, input logic [2:0] n);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[(i + n) % 8];
    end
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Mostly a small cluster of low addresses so reads hit earlier writes,
  // with some top-of-plane and fully random addresses mixed in.
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'hFFF0 | 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  // Register value: forced high or low in the first phases, then mixed.
  function automatic logic [7:0] pick_setting(input int hi, input int phase);
    if (phase == 0) begin
      return 8'(hi);
    end
    if (phase == 1) begin
      return 8'h00;
    end
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'(hi);
      default: return 8'($urandom_range(0, hi));
    endcase
  endfunction

  // Apply one accepted access to the shadow planes and queue a read result.
  task automatic predict_access(input logic req, input logic [15:0] addr,
                                input logic [7:0] data);
    pvma_pkg::word_t srx;
    pvma_pkg::word_t sre;
    pvma_pkg::word_t src;
    pvma_pkg::word_t sel;
    pvma_pkg::word_t merged;
    pvma_pkg::word_t enables;
    if (req == pvma_pkg::REQ_READ) begin
      latch_shadow = vram_shadow[addr];
      pending_read_bytes.push_back(latch_shadow[gc_read_plane]);
    end else begin
      srx = plane_spread(gc_sr_value);
      sre = plane_spread(gc_sr_enable);
      sel = all_planes(gc_bit_mask);
      case (gc_write_mode)
        pvma_pkg::WMODE_0:
          src = (all_planes(rotate_byte(data, gc_rotate)) & ~sre) | (srx & sre);
        pvma_pkg::WMODE_2: src = plane_spread(data[3:0]);
        pvma_pkg::WMODE_3: begin
          src = srx;
          sel = all_planes(rotate_byte(data, gc_rotate) & gc_bit_mask);
        end
        default: src = latch_shadow;
      endcase
      if (gc_write_mode == pvma_pkg::WMODE_1) begin
        merged = latch_shadow;
      end else begin
        case (gc_alu_op)
          pvma_pkg::ALU_AND: src = src & latch_shadow;
          pvma_pkg::ALU_OR:  src = src | latch_shadow;
          pvma_pkg::ALU_XOR: src = src ^ latch_shadow;
          default: ;
        endcase
        merged = (src & sel) | (latch_shadow & ~sel);
      end
      enables = plane_spread(gc_map_mask);
      vram_shadow[addr] = (vram_shadow[addr] & ~enables) | (merged & enables);
    end
  endtask

  // Present one item after a random gap and hold it until accepted.
  task automatic send_access(input logic req, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_req_type   = req;
    in_address    = addr;
    in_write_data = data;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_access(req, addr, data);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      pvma_pkg::CFG_WRITE_MODE:        gc_write_mode = value[1:0];
      pvma_pkg::CFG_READ_PLANE_SELECT: gc_read_plane = value[1:0];
      pvma_pkg::CFG_SET_RESET_VALUE:   gc_sr_value   = value[3:0];
      pvma_pkg::CFG_SET_RESET_ENABLE:  gc_sr_enable  = value[3:0];
      pvma_pkg::CFG_ALU_FUNCTION:      gc_alu_op     = value[1:0];
      pvma_pkg::CFG_ROTATE_COUNT:      gc_rotate     = value[2:0];
      pvma_pkg::CFG_BIT_MASK:          gc_bit_mask   = value;
      default:                         gc_map_mask   = value[3:0];
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Stop sending, wait for every owed read, then let the pipeline empty.
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_read_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The receiver stalls for a random number of cycles after each item it takes.
  always @(negedge clk) begin
    out_stall <= (reader_hold > 0);
    if (reader_hold > 0) begin
      reader_hold--;
    end
  end

  // Compare each taken result with the oldest owed read byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_read_bytes.size() == 0) begin
        $error("read_data: no result expected, actual %02h", out_read_data);
        error_count++;
      end else begin
        if (out_read_data !== pending_read_bytes[0]) begin
          $error("read_data mismatch: expected %02h, actual %02h",
                 pending_read_bytes[0], out_read_data);
          error_count++;
        end
        void'(pending_read_bytes.pop_front());
      end
      reader_hold = draw_wait();
    end
  end

  // Freshly reset planes read back as zero at both ends and in between.
  task automatic test_cleared_planes();
    send_access(pvma_pkg::REQ_READ, 16'h0000, 8'h00);
    send_access(pvma_pkg::REQ_READ, 16'hFFFF, 8'hFF);
    send_access(pvma_pkg::REQ_READ, 16'($urandom_range(0, 65535)), 8'h5A);
    send_access(pvma_pkg::REQ_WRITE, 16'h0000, 8'hFF);
    send_access(pvma_pkg::REQ_READ, 16'h0000, 8'h00);
  endtask

  // Every write mode and ALU function, with rotate, set/reset and masks.
  task automatic test_write_modes();
    settle_idle();
    write_reg(pvma_pkg::CFG_PLANE_WRITE_MASK, 8'h0F);
    write_reg(pvma_pkg::CFG_BIT_MASK, 8'hFF);
    send_access(pvma_pkg::REQ_WRITE, 16'h0000, 8'hA5);
    send_access(pvma_pkg::REQ_WRITE, 16'hFFFF, 8'hFF);
    send_access(pvma_pkg::REQ_READ, 16'h0000, 8'h00);
    send_access(pvma_pkg::REQ_READ, 16'hFFFF, 8'h00);

    settle_idle();
    write_reg(pvma_pkg::CFG_ROTATE_COUNT, 8'h07);
    write_reg(pvma_pkg::CFG_SET_RESET_ENABLE, 8'h05);
    write_reg(pvma_pkg::CFG_SET_RESET_VALUE, 8'h0A);
    write_reg(pvma_pkg::CFG_ALU_FUNCTION, {6'd0, pvma_pkg::ALU_XOR});
    write_reg(pvma_pkg::CFG_BIT_MASK, 8'h0F);
    write_reg(pvma_pkg::CFG_READ_PLANE_SELECT, 8'h03);
    send_access(pvma_pkg::REQ_WRITE, 16'h0000, 8'h3C);
    send_access(pvma_pkg::REQ_READ, 16'h0000, 8'h00);
    send_access(pvma_pkg::REQ_WRITE, 16'h1234, 8'h00);
    send_access(pvma_pkg::REQ_READ, 16'h1234, 8'h00);

    // Latch copy into a subset of planes.
    settle_idle();
    write_reg(pvma_pkg::CFG_WRITE_MODE, {6'd0, pvma_pkg::WMODE_1});
    write_reg(pvma_pkg::CFG_PLANE_WRITE_MASK, 8'h06);
    write_reg(pvma_pkg::CFG_READ_PLANE_SELECT, 8'h01);
    send_access(pvma_pkg::REQ_READ, 16'hFFFF, 8'h00);
    send_access(pvma_pkg::REQ_WRITE, 16'h0001, 8'h00);
    send_access(pvma_pkg::REQ_READ, 16'h0001, 8'h00);

    settle_idle();
    write_reg(pvma_pkg::CFG_WRITE_MODE, {6'd0, pvma_pkg::WMODE_2});
    write_reg(pvma_pkg::CFG_ALU_FUNCTION, {6'd0, pvma_pkg::ALU_AND});
    write_reg(pvma_pkg::CFG_PLANE_WRITE_MASK, 8'h0F);
    write_reg(pvma_pkg::CFG_BIT_MASK, 8'h00);
    send_access(pvma_pkg::REQ_READ, 16'h0000, 8'h00);
    send_access(pvma_pkg::REQ_WRITE, 16'h0002, 8'hF5);
    send_access(pvma_pkg::REQ_READ, 16'h0002, 8'h00);

    settle_idle();
    write_reg(pvma_pkg::CFG_WRITE_MODE, {6'd0, pvma_pkg::WMODE_3});
    write_reg(pvma_pkg::CFG_ALU_FUNCTION, {6'd0, pvma_pkg::ALU_OR});
    write_reg(pvma_pkg::CFG_ROTATE_COUNT, 8'h03);
    write_reg(pvma_pkg::CFG_BIT_MASK, 8'hF0);
    write_reg(pvma_pkg::CFG_SET_RESET_VALUE, 8'h0F);
    send_access(pvma_pkg::REQ_WRITE, 16'h0004, 8'h81);
    send_access(pvma_pkg::REQ_READ, 16'h0004, 8'h00);
    send_access(pvma_pkg::REQ_WRITE, 16'h0004, 8'h7E);
  endtask

  // Random register settings per phase, then mostly read-then-write
  // sequences on one address with some unpaired accesses as noise.
  task automatic test_random_traffic();
    logic [15:0] addr;
    int          sent;
    int          writes;
    for (int phase = 0; phase < 12; phase++) begin
      settle_idle();
      write_reg(pvma_pkg::CFG_WRITE_MODE,        pick_setting(3, phase));
      write_reg(pvma_pkg::CFG_READ_PLANE_SELECT, pick_setting(3, phase));
      write_reg(pvma_pkg::CFG_SET_RESET_VALUE,   pick_setting(15, phase));
      write_reg(pvma_pkg::CFG_SET_RESET_ENABLE,  pick_setting(15, phase));
      write_reg(pvma_pkg::CFG_ALU_FUNCTION,      pick_setting(3, phase));
      write_reg(pvma_pkg::CFG_ROTATE_COUNT,      pick_setting(7, phase));
      write_reg(pvma_pkg::CFG_BIT_MASK,          pick_setting(255, phase));
      write_reg(pvma_pkg::CFG_PLANE_WRITE_MASK,  pick_setting(15, phase));
      no_idle = (phase % 4 == 3);
      sent = 0;
      while (sent < 44) begin
        addr = pick_address();
        if ($urandom_range(0, 9) < 6) begin
          send_access(pvma_pkg::REQ_READ, addr, 8'($urandom_range(0, 255)));
          writes = $urandom_range(1, 2);
          for (int w = 0; w < writes; w++) begin
            send_access(pvma_pkg::REQ_WRITE, addr, 8'($urandom_range(0, 255)));
          end
          send_access(pvma_pkg::REQ_READ, addr, 8'($urandom_range(0, 255)));
          sent += writes + 2;
        end else begin
          send_access(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = pvma_pkg::REQ_READ;
    in_address    = '0;
    in_write_data = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = pvma_pkg::CFG_WRITE_MODE;
    cfg_wdata     = '0;
    error_count   = 0;
    reader_hold   = 0;
    no_idle       = 1'b0;
    latch_shadow  = '0;
    gc_write_mode = pvma_pkg::WMODE_0;
    gc_read_plane = '0;
    gc_sr_value   = '0;
    gc_sr_enable  = '0;
    gc_alu_op     = pvma_pkg::ALU_COPY;
    gc_rotate     = '0;
    gc_bit_mask   = '0;
    gc_map_mask   = '0;
    foreach (vram_shadow[i]) begin
      vram_shadow[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_cleared_planes();
    test_write_modes();
    test_random_traffic();
    settle_idle();

    if (error_count == 0) begin
      $display("tb_planar_video_memory_access_unit: PASS");
    end else begin
      $display("tb_planar_video_memory_access_unit: FAIL");
    end
    $finish;
  end

  // Covers the clearing pass after reset plus the slowest stalled traffic.
  initial begin
    #5ms;
    $display("tb_planar_video_memory_access_unit: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pvma_pkg.sv
rtl/core/planar_video_memory_access_unit.sv
dv/tb_planar_video_memory_access_unit.sv
